### hw/rtl/fmq_pkg.sv
// Shared types and constants for the FM chip port write queue.
package fmq_pkg;

    typedef enum logic [1:0] {
        OP_PORT_WRITE = 2'd0,
        OP_PORT_READ  = 2'd1,
        OP_POP        = 2'd2
    } op_t;

    localparam logic [15:0] PORT_ADDR0 = 16'h0388;
    localparam logic [15:0] PORT_DATA0 = 16'h0389;
    localparam logic [15:0] PORT_ADDR1 = 16'h038A;
    localparam logic [15:0] PORT_DATA1 = 16'h038B;

    localparam logic [8:0] TIMER_REG      = 9'h004;
    localparam logic [7:0] TIMER_RESET    = 8'h80;
    localparam logic [7:0] TIMER1_START   = 8'h01;
    localparam logic [7:0] TIMER2_START   = 8'h02;
    localparam logic [7:0] TIMER1_STATUS  = 8'hC0;
    localparam logic [7:0] TIMER2_STATUS  = 8'hA0;
    localparam logic [8:0] BANK1_OFFSET   = 9'h100;
    localparam logic [7:0] IDLE_BUS_BYTE  = 8'hFF;

    localparam int ENTRY_W = 17;

    // Per-word result that travels from the port controller to the output stage.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       pop_hit;
        logic       write_dropped;
    } stage_res_t;

endpackage

### hw/rtl/fmq_ring_ram.sv
// Single-port-write, single-port-read ring storage with a registered read.
module fmq_ring_ram #(
    parameter int QUEUE_DEPTH = 8192,
    parameter int AW          = 13
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [fmq_pkg::ENTRY_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [fmq_pkg::ENTRY_W-1:0] rdata
);
    import fmq_pkg::*;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read until the next read enable.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/fmq_port_ctrl.sv
// Port decode, address latches, timer status and ring pointers.
module fmq_port_ctrl #(
    parameter int QUEUE_DEPTH = 8192,
    parameter int AW          = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  operation,
    input  logic [15:0]                 port,
    input  logic [7:0]                  write_byte,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [fmq_pkg::ENTRY_W-1:0] ram_wdata,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr,
    output fmq_pkg::stage_res_t         res
);
    import fmq_pkg::*;

    logic [7:0]    bank0_reg, bank0_next;
    logic [7:0]    bank1_reg, bank1_next;
    logic [7:0]    status_reg, status_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic          ring_full;
    logic          ring_empty;
    logic          data_write;
    logic [8:0]    reg_num;
    op_t           op;

    assign op       = op_t'(operation);
    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign ring_full  = (head_inc == tail_reg);
    assign ring_empty = (head_reg == tail_reg);

    always_comb
    begin
        bank0_next  = bank0_reg;
        bank1_next  = bank1_reg;
        status_next = status_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        data_write  = 1'b0;
        reg_num     = {1'b0, bank0_reg};
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        res         = '0;

        if (port == PORT_DATA1)
        begin
            reg_num = BANK1_OFFSET | {1'b0, bank1_reg};
        end

        if (accept)
        begin
            unique case (op)
                OP_PORT_WRITE:
                begin
                    if (port == PORT_ADDR0)
                    begin
                        bank0_next = write_byte;
                    end
                    else if (port == PORT_ADDR1)
                    begin
                        bank1_next = write_byte;
                    end
                    else if (port == PORT_DATA0 || port == PORT_DATA1)
                    begin
                        data_write = 1'b1;
                    end
                end
                OP_PORT_READ:
                begin
                    res.read_byte = (port == PORT_ADDR0) ? status_reg : IDLE_BUS_BYTE;
                end
                OP_POP:
                begin
                    if (!ring_empty)
                    begin
                        ram_re      = 1'b1;
                        res.pop_hit = 1'b1;
                        tail_next   = tail_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (data_write)
        begin
            // Timer status updates even when the push is dropped.
            if (reg_num == TIMER_REG)
            begin
                if ((write_byte & TIMER_RESET) != 8'h00)
                begin
                    status_next = 8'h00;
                end
                else
                begin
                    status_next = (((write_byte & TIMER1_START) != 8'h00) ? TIMER1_STATUS : 8'h00)
                                | (((write_byte & TIMER2_START) != 8'h00) ? TIMER2_STATUS : 8'h00);
                end
            end
            if (ring_full)
            begin
                res.write_dropped = 1'b1;
            end
            else
            begin
                ram_we    = 1'b1;
                head_next = head_inc;
            end
        end
    end

    assign ram_waddr = head_reg;
    assign ram_wdata = {reg_num, write_byte};
    assign ram_raddr = tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank0_reg  <= '0;
            bank1_reg  <= '0;
            status_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
        end
        else
        begin
            bank0_reg  <= bank0_next;
            bank1_reg  <= bank1_next;
            status_reg <= status_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    a_no_push_pop_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ring push and pop in the same cycle");

    a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (head_reg != tail_reg))
        else $error("ring read issued on an empty ring");

    a_push_leaves_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && rst_n) |=> (head_reg != tail_reg))
        else $error("ring empty right after a push");

endmodule

### hw/rtl/fm_chip_port_write_queue.sv
// Top level of the FM chip port write queue: bus front end and register-write ring.
//
// Usage: each input word carries one bus item (operation, port, write_byte) and
// produces exactly one output word (read_byte, pop_valid, pop_register,
// pop_value, write_dropped). Operation 0 is a port write: 0x388/0x38A latch a
// bank 0/1 register address, 0x389/0x38B push (register, value) into the ring
// and may update the timer status (register 0x04). Operation 1 is a port read
// (status at 0x388, 0xFF elsewhere). Operation 2 pops the oldest queued write.
// Both channels handshake with valid and stall; a word moves on an edge where
// valid is high and stall is low.
// A result passes through the read stage (the ring's registered read) and then
// the output register before it appears on out_valid.
// Throughput: one word per cycle while out_stall is low (one ring access per item).
// When out_stall holds the output register, one more word can sit in the
// read stage; after that in_stall rises until the output drains.
// Reset clears the address latches, timer status and ring pointers at once;
// the ring storage itself is not cleared and needs no clearing pass, since
// only entries that were pushed are ever popped.
module fm_chip_port_write_queue #(
    parameter int QUEUE_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] port,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic        pop_valid,
    output logic [8:0]  pop_register,
    output logic [7:0]  pop_value,
    output logic        write_dropped
);
    import fmq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    stage_res_t         ctrl_res;

    // Read stage: holds the item's result while the ring's registered read completes.
    logic               s1_valid_reg;
    stage_res_t         s1_res_reg;

    // Output register.
    logic               s2_valid_reg;
    logic [7:0]         read_byte_reg;
    logic               pop_valid_reg;
    logic [8:0]         pop_register_reg;
    logic [7:0]         pop_value_reg;
    logic               write_dropped_reg;

    logic               s2_free;
    logic               s1_move;

    assign s2_free  = !s2_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign accept   = in_valid && !in_stall;

    fmq_port_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .port       (port),
        .write_byte (write_byte),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .res        (ctrl_res)
    );

    // The pop of an entry is taken only after its push has moved the head pointer, and
    // the write lands before that read, so no forwarding is needed.
    fmq_ring_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance the read stage; ring data holds because no read is issued while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= ctrl_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    // Load the output word; zero the pop fields unless the pop hit.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            read_byte_reg     <= s1_res_reg.read_byte;
            pop_valid_reg     <= s1_res_reg.pop_hit;
            pop_register_reg  <= s1_res_reg.pop_hit ? ram_rdata[ENTRY_W-1:8] : 9'd0;
            pop_value_reg     <= s1_res_reg.pop_hit ? ram_rdata[7:0] : 8'd0;
            write_dropped_reg <= s1_res_reg.write_dropped;
        end
    end

    assign out_valid     = s2_valid_reg;
    assign read_byte     = read_byte_reg;
    assign pop_valid     = pop_valid_reg;
    assign pop_register  = pop_register_reg;
    assign pop_value     = pop_value_reg;
    assign write_dropped = write_dropped_reg;

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with a free pipeline slot");

    a_pop_excludes_others: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pop_valid) |-> (read_byte == 8'd0 && !write_dropped))
        else $error("pop result mixed with read or drop");

    a_miss_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pop_valid) |-> (pop_register == 9'd0 && pop_value == 8'd0))
        else $error("pop fields nonzero without a pop hit");

endmodule

### sim/fm_chip_port_write_queue_tb.sv
// Self-checking testbench for the FM chip port write queue.
module fm_chip_port_write_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fmq_pkg::*;

    // Keep this in step with the queue depth handed to the block.
    localparam int QUEUE_DEPTH = 8192;
    // One slot of the ring always stays empty.
    localparam int RING_SLOTS = QUEUE_DEPTH - 1;
    // Operation code that the block has no use for.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Cycles to let pass once nothing is pending; covers the two-stage pipe.
    localparam int SETTLE_CYCLES = 8;
    // About 18k words at worst-case sender gaps and receiver stalls, several times over.
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       pop_valid;
        logic [8:0] pop_register;
        logic [7:0] pop_value;
        logic       write_dropped;
    } bus_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_PORT_WRITE;
    logic [15:0] port = 16'h0000;
    logic [7:0]  write_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_byte;
    logic        pop_valid;
    logic [8:0]  pop_register;
    logic [7:0]  pop_value;
    logic        write_dropped;

    // Shadow copy of the chip front end: address latches, timer status, queued writes.
    logic [7:0]  bank0_latch = 8'h00;
    logic [7:0]  bank1_latch = 8'h00;
    logic [7:0]  status_byte = 8'h00;
    logic [16:0] queued_writes[$];

    // Results still owed by the block, oldest first.
    bus_result_t pending_results[$];
    bus_result_t oldest_result;

    int error_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int drops_seen = 0;
    int pops_hit = 0;
    int burst_left = 0;
    int cycle_count = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int stall_left = 0;

    fm_chip_port_write_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .port(port),
        .write_byte(write_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_byte(read_byte),
        .pop_valid(pop_valid),
        .pop_register(pop_register),
        .pop_value(pop_value),
        .write_dropped(write_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs a handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: switch between stall patterns at random intervals so that stalls
    // land on every pipeline phase, with clean stretches in between.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 256);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: out_stall <= ((stall_left % 8) < 3);
            default:        out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Checker: compare every word taken from the output against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: read_byte 0x%0h pop_valid %0b",
                       read_byte, pop_valid);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("read_byte", oldest_result.read_byte, read_byte);
                check_field("pop_valid", oldest_result.pop_valid, pop_valid);
                check_field("pop_register", oldest_result.pop_register, pop_register);
                check_field("pop_value", oldest_result.pop_value, pop_value);
                check_field("write_dropped", oldest_result.write_dropped, write_dropped);
                results_checked++;
                if (oldest_result.write_dropped)
                    drops_seen++;
                if (oldest_result.pop_valid)
                    pops_hit++;
            end
        end
    end

    // Apply one chip register write to the shadow state; return 1 when the ring is full.
    function automatic logic apply_register_write(input logic [8:0] reg_num,
                                                  input logic [7:0] value);
        if (reg_num == TIMER_REG)
        begin
            if ((value & TIMER_RESET) != 8'h00)
                status_byte = 8'h00;
            else
                status_byte = (((value & TIMER1_START) != 8'h00) ? TIMER1_STATUS : 8'h00)
                            | (((value & TIMER2_START) != 8'h00) ? TIMER2_STATUS : 8'h00);
        end
        if (queued_writes.size() >= RING_SLOTS)
            return 1'b1;
        queued_writes.push_back({reg_num, value});
        return 1'b0;
    endfunction

    // Advance the shadow state by one bus word and return the result it should produce.
    function automatic bus_result_t predict_bus_result(input logic [1:0] bus_op,
                                                       input logic [15:0] bus_port,
                                                       input logic [7:0] bus_byte);
        bus_result_t res;
        logic [16:0] entry;
        res = '0;
        if (bus_op == OP_PORT_WRITE)
        begin
            if (bus_port == PORT_ADDR0)
                bank0_latch = bus_byte;
            else if (bus_port == PORT_DATA0)
                res.write_dropped = apply_register_write({1'b0, bank0_latch}, bus_byte);
            else if (bus_port == PORT_ADDR1)
                bank1_latch = bus_byte;
            else if (bus_port == PORT_DATA1)
                res.write_dropped = apply_register_write(BANK1_OFFSET | {1'b0, bank1_latch},
                                                         bus_byte);
        end
        else if (bus_op == OP_PORT_READ)
        begin
            res.read_byte = (bus_port == PORT_ADDR0) ? status_byte : IDLE_BUS_BYTE;
        end
        else if (bus_op == OP_POP)
        begin
            if (queued_writes.size() != 0)
            begin
                entry = queued_writes.pop_front();
                res.pop_valid = 1'b1;
                res.pop_register = entry[16:8];
                res.pop_value = entry[7:0];
            end
        end
        return res;
    endfunction

    // Drive one word, hold it until the block takes it, then record the prediction.
    // Bursts end at random with a gap in which valid is low, so valid is
    // never lowered and raised in the same step.
    task automatic send_word(input logic [1:0] bus_op, input logic [15:0] bus_port,
                             input logic [7:0] bus_byte);
        int gap;
        operation  <= bus_op;
        port       <= bus_port;
        write_byte <= bus_byte;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_bus_result(bus_op, bus_port, bus_byte));
        words_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Hold off the sender until every pending result has come back, then settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset values, every operation, the timer encodings, bank 1 numbering,
    // ignored ports, the spare opcode and a pop from an empty ring.
    task automatic test_directed();
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_READ, PORT_DATA0, 8'hFF);
        send_word(OP_PORT_READ, 16'hFFFF, 8'h00);
        send_word(OP_POP, 16'h0000, 8'hFF);
        send_word(OP_SPARE, PORT_DATA0, 8'hAA);
        send_word(OP_PORT_WRITE, 16'h0000, 8'hFF);
        send_word(OP_PORT_WRITE, 16'hFFFF, 8'h55);
        send_word(OP_PORT_WRITE, PORT_ADDR0, TIMER_REG[7:0]);
        send_word(OP_PORT_WRITE, PORT_DATA0, TIMER1_START);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_WRITE, PORT_DATA0, TIMER1_START | TIMER2_START);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_WRITE, PORT_DATA0, 8'h83);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_WRITE, PORT_DATA0, TIMER2_START);
        send_word(OP_PORT_WRITE, PORT_ADDR1, TIMER_REG[7:0]);
        send_word(OP_PORT_WRITE, PORT_DATA1, TIMER1_START);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_WRITE, PORT_ADDR1, 8'hFF);
        send_word(OP_PORT_WRITE, PORT_DATA1, 8'hFF);
        send_word(OP_PORT_WRITE, PORT_DATA0, 8'h00);
        repeat (6) send_word(OP_POP, 16'h0000, 8'h00);
    endtask

    // Fill the ring to its last free slot, overflow it (a timer write among the
    // dropped ones must still move the status), then drain it and pop once more.
    task automatic test_ring_full();
        int backlog;
        int i;
        backlog = queued_writes.size();
        for (i = 0; i < backlog; i++)
            send_word(OP_POP, 16'h0000, 8'h00);
        for (i = 0; i < RING_SLOTS; i++)
        begin
            if ((i % 64) == 0)
                send_word(OP_PORT_WRITE, ($urandom_range(0, 1) == 0) ? PORT_ADDR0 : PORT_ADDR1,
                          8'($urandom_range(0, 255)));
            send_word(OP_PORT_WRITE, ($urandom_range(0, 1) == 0) ? PORT_DATA0 : PORT_DATA1,
                      8'($urandom_range(0, 255)));
        end
        send_word(OP_PORT_WRITE, PORT_DATA1, 8'h5A);
        send_word(OP_PORT_WRITE, PORT_ADDR0, TIMER_REG[7:0]);
        send_word(OP_PORT_WRITE, PORT_DATA0, TIMER1_START);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        send_word(OP_PORT_WRITE, PORT_DATA0, TIMER_RESET);
        send_word(OP_PORT_READ, PORT_ADDR0, 8'h00);
        wait_drained();
        for (i = 0; i < RING_SLOTS; i++)
            send_word(OP_POP, 16'h0000, 8'h00);
        send_word(OP_POP, 16'h0000, 8'h00);
    endtask

    // Mostly well-formed register writes (address then data) with random content,
    // plus reads, pops, and some noise on random ports and opcodes.
    task automatic test_random_traffic(input int word_count, input int pop_percent);
        int counted;
        int pick;
        logic use_bank1;
        counted = 0;
        while (counted < word_count)
        begin
            pick = $urandom_range(0, 99);
            use_bank1 = 1'($urandom_range(0, 1));
            if (pick < pop_percent)
            begin
                send_word(OP_POP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                counted++;
            end
            else if (pick < pop_percent + 12)
            begin
                send_word(OP_PORT_READ,
                          ($urandom_range(0, 2) != 0) ? PORT_ADDR0 : 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)));
                counted++;
            end
            else if (pick < 93)
            begin
                // Favor the timer register so its encodings get exercised often.
                if ($urandom_range(0, 3) != 0)
                begin
                    send_word(OP_PORT_WRITE, use_bank1 ? PORT_ADDR1 : PORT_ADDR0,
                              ($urandom_range(0, 3) == 0) ? TIMER_REG[7:0]
                                                          : 8'($urandom_range(0, 255)));
                    counted++;
                end
                send_word(OP_PORT_WRITE, use_bank1 ? PORT_DATA1 : PORT_DATA0,
                          8'($urandom_range(0, 255)));
                counted++;
            end
            else
            begin
                // Noise: the block should ignore most of these.
                send_word(($urandom_range(0, 1) == 0) ? OP_SPARE : OP_PORT_WRITE,
                          16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        // Hold reset low from the start, then release it on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        test_ring_full();
        wait_drained();
        test_random_traffic(500, 35);
        wait_drained();
        test_random_traffic(500, 15);
        wait_drained();

        $display("Covered %0d bus words: reads, timer writes, bank 0/1 queueing, pops",
                 words_sent);
        $display("and a full-ring overflow; %0d results checked, %0d drops, %0d pops hit",
                 results_checked, drops_seen, pops_hit);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
